@@ rtl/core/median3_sensor_fault_filter_macros.svh @@
// ----------------------------------------------------------------------------
// median3_sensor_fault_filter_macros
// assertion helpers shared by the checker of the median filter
// ----------------------------------------------------------------------------
`ifndef MEDIAN3_SENSOR_FAULT_FILTER_MACROS_SVH
`define MEDIAN3_SENSOR_FAULT_FILTER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define M3SF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("median3 filter check failed");

// next-cycle implication, disabled while reset is asserted
`define M3SF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("median3 filter check failed");

`endif

@@ rtl/core/m3sf_pkg.sv @@
// ----------------------------------------------------------------------------
// m3sf_pkg
// types and constants of the median-of-three sensor fault filter
// ----------------------------------------------------------------------------
package m3sf_pkg;

    localparam int DIST_W   = 16;
    localparam int COUNT_W  = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W    = 16;

    localparam logic [COUNT_W-1:0] SAT_LIMIT         = 8'hFF;
    localparam logic [COUNT_W-1:0] THRESHOLD_RESET   = 8'd3;
    localparam logic [COUNT_W-1:0] RECOVERY_RESET    = 8'd3;
    localparam logic [DIST_W-1:0]  UNKNOWN_RESET     = 16'hFFFF;

    typedef logic [DIST_W-1:0]  dist_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [1:0]         slot_t;

    localparam slot_t LAST_SLOT = 2'd2;

    typedef enum logic
    {
        OP_SAMPLE = 1'b0,
        OP_FAULT  = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        CFG_FAULT_THRESHOLD  = 2'd0,
        CFG_RECOVERY_COUNT   = 2'd1,
        CFG_UNKNOWN_DISTANCE = 2'd2
    } cfg_idx_t;

endpackage

@@ rtl/core/m3sf_median3.sv @@
// ----------------------------------------------------------------------------
// m3sf_median3
// combinational median of three unsigned distances
// ----------------------------------------------------------------------------
module m3sf_median3
(
    input  m3sf_pkg::dist_t a,
    input  m3sf_pkg::dist_t b,
    input  m3sf_pkg::dist_t c,
    output m3sf_pkg::dist_t median
);

    m3sf_pkg::dist_t lo;
    m3sf_pkg::dist_t hi;

    assign lo = (a < b) ? a : b;
    assign hi = (a < b) ? b : a;

    always_comb
    begin
        if (c <= lo)
        begin
            median = lo;
        end
        else if (c >= hi)
        begin
            median = hi;
        end
        else
        begin
            median = c;
        end
    end

endmodule

@@ rtl/core/median3_sensor_fault_filter.sv @@
// ----------------------------------------------------------------------------
// median3_sensor_fault_filter
// path: input register, then result register, from input transaction to result transaction
// throughput: one event per clock without output stall, set by window and counter update
// reset: asynchronous active low, empties the window, clears counters, restores registers
// ----------------------------------------------------------------------------
module median3_sensor_fault_filter
(
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_we,
    input  logic [m3sf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [m3sf_pkg::CFG_W-1:0]        cfg_data,
    // event input
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [15:0]                       s_axis_tdata,  // [15:0] distance
    input  logic                              s_axis_tuser,  // [0] operation
    // result output
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [15:0]                       m_axis_tdata,  // [15:0] filtered_distance
    output logic                              m_axis_tuser   // [0] status
);

    // configuration registers
    m3sf_pkg::count_t threshold_reg;
    m3sf_pkg::count_t recovery_reg;
    m3sf_pkg::dist_t  unknown_reg;

    // input stage
    logic             in_valid_reg;
    m3sf_pkg::op_t    in_op_reg;
    m3sf_pkg::dist_t  in_dist_reg;

    // result stage
    logic             out_valid_reg;
    logic             out_status_reg;
    m3sf_pkg::dist_t  out_dist_reg;

    // filter state
    m3sf_pkg::dist_t  win_reg [3];
    m3sf_pkg::dist_t  win_next [3];
    logic             filled_reg;
    logic             filled_next;
    m3sf_pkg::slot_t  slot_reg;
    m3sf_pkg::slot_t  slot_next;
    logic             fault_reg;
    logic             fault_next;
    m3sf_pkg::count_t fault_run_reg;
    m3sf_pkg::count_t fault_run_next;
    m3sf_pkg::count_t valid_run_reg;
    m3sf_pkg::count_t valid_run_next;
    m3sf_pkg::dist_t  last_median_reg;
    m3sf_pkg::dist_t  last_median_next;

    m3sf_pkg::dist_t  median;
    m3sf_pkg::count_t fault_run_inc;
    m3sf_pkg::count_t valid_run_inc;
    m3sf_pkg::dist_t  result_dist;
    logic             advance;
    logic             fire;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_dist_reg;
    assign m_axis_tuser  = out_status_reg;

    // configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= m3sf_pkg::THRESHOLD_RESET;
            recovery_reg  <= m3sf_pkg::RECOVERY_RESET;
            unknown_reg   <= m3sf_pkg::UNKNOWN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (m3sf_pkg::cfg_idx_t'(cfg_index))
                m3sf_pkg::CFG_FAULT_THRESHOLD:
                begin
                    threshold_reg <= cfg_data[m3sf_pkg::COUNT_W-1:0];
                end
                m3sf_pkg::CFG_RECOVERY_COUNT:
                begin
                    recovery_reg <= cfg_data[m3sf_pkg::COUNT_W-1:0];
                end
                m3sf_pkg::CFG_UNKNOWN_DISTANCE:
                begin
                    unknown_reg <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_op_reg   <= m3sf_pkg::op_t'(s_axis_tuser);
            in_dist_reg <= s_axis_tdata;
        end
    end

    // window after this sample
    always_comb
    begin
        win_next[0] = win_reg[0];
        win_next[1] = win_reg[1];
        win_next[2] = win_reg[2];
        if (!filled_reg)
        begin
            win_next[0] = in_dist_reg;
            win_next[1] = in_dist_reg;
            win_next[2] = in_dist_reg;
        end
        else
        begin
            case (slot_reg)
                2'd0:    win_next[0] = in_dist_reg;
                2'd1:    win_next[1] = in_dist_reg;
                default: win_next[2] = in_dist_reg;
            endcase
        end
    end

    m3sf_median3 u_median3
    (
        .a      (win_next[0]),
        .b      (win_next[1]),
        .c      (win_next[2]),
        .median (median)
    );

    assign fault_run_inc = (fault_run_reg == m3sf_pkg::SAT_LIMIT) ?
                           fault_run_reg : fault_run_reg + 8'd1;
    assign valid_run_inc = (valid_run_reg == m3sf_pkg::SAT_LIMIT) ?
                           valid_run_reg : valid_run_reg + 8'd1;

    // state update for one event
    always_comb
    begin
        filled_next      = filled_reg;
        slot_next        = slot_reg;
        fault_next       = fault_reg;
        fault_run_next   = fault_run_reg;
        valid_run_next   = valid_run_reg;
        last_median_next = last_median_reg;
        if (in_op_reg == m3sf_pkg::OP_SAMPLE)
        begin
            fault_run_next   = '0;
            filled_next      = 1'b1;
            last_median_next = median;
            if (filled_reg)
            begin
                slot_next = (slot_reg == m3sf_pkg::LAST_SLOT) ? 2'd0 : slot_reg + 2'd1;
            end
            if (fault_reg)
            begin
                if (valid_run_inc >= recovery_reg)
                begin
                    fault_next     = 1'b0;
                    valid_run_next = '0;
                end
                else
                begin
                    valid_run_next = valid_run_inc;
                end
            end
        end
        else
        begin
            valid_run_next = '0;
            fault_run_next = fault_run_inc;
            if (fault_run_inc >= threshold_reg)
            begin
                fault_next       = 1'b1;
                filled_next      = 1'b0;
                slot_next        = '0;
                last_median_next = unknown_reg;
            end
        end
        result_dist = fault_next ? unknown_reg : last_median_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg[0]      <= '0;
            win_reg[1]      <= '0;
            win_reg[2]      <= '0;
            filled_reg      <= 1'b0;
            slot_reg        <= '0;
            fault_reg       <= 1'b0;
            fault_run_reg   <= '0;
            valid_run_reg   <= '0;
            last_median_reg <= m3sf_pkg::UNKNOWN_RESET;
        end
        else if (fire)
        begin
            if (in_op_reg == m3sf_pkg::OP_SAMPLE)
            begin
                win_reg[0] <= win_next[0];
                win_reg[1] <= win_next[1];
                win_reg[2] <= win_next[2];
            end
            filled_reg      <= filled_next;
            slot_reg        <= slot_next;
            fault_reg       <= fault_next;
            fault_run_reg   <= fault_run_next;
            valid_run_reg   <= valid_run_next;
            last_median_reg <= last_median_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_status_reg <= fault_next;
            out_dist_reg   <= result_dist;
        end
    end

endmodule

@@ rtl/core/m3sf_checker.sv @@
// ----------------------------------------------------------------------------
// m3sf_checker
// port-level checks of the median filter, attached to the top level by bind
// ----------------------------------------------------------------------------
`include "median3_sensor_fault_filter_macros.svh"

module m3sf_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           cfg_we,
    input logic [m3sf_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic [m3sf_pkg::CFG_W-1:0]     cfg_data,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [15:0]                    m_axis_tdata,
    input logic                           m_axis_tuser
);

    m3sf_pkg::dist_t unknown_reg;
    logic [2:0]      pending_reg;
    logic [2:0]      pending_next;
    logic            in_xact;
    logic            out_xact;

    assign in_xact  = s_axis_tvalid && s_axis_tready;
    assign out_xact = m_axis_tvalid && m_axis_tready;

    // shadow of the unknown distance register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unknown_reg <= m3sf_pkg::UNKNOWN_RESET;
        end
        else if (cfg_we && (cfg_index == m3sf_pkg::CFG_UNKNOWN_DISTANCE))
        begin
            unknown_reg <= cfg_data;
        end
    end

    // transactions accepted but not yet delivered
    always_comb
    begin
        pending_next = pending_reg;
        if (in_xact && !out_xact)
        begin
            pending_next = pending_reg + 3'd1;
        end
        else if (!in_xact && out_xact)
        begin
            pending_next = pending_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    `M3SF_ASSERT_NOW(a_faulted_reads_unknown, clk, rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata == unknown_reg)
    `M3SF_ASSERT_NOW(a_result_has_source, clk, rst_n, m_axis_tvalid, (pending_reg != 3'd0) && (pending_reg <= 3'd2))
    `M3SF_ASSERT_NEXT(a_valid_holds, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `M3SF_ASSERT_NEXT(a_payload_holds, clk, rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind median3_sensor_fault_filter m3sf_checker u_m3sf_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
